// ===== design/lrsr_pkg.sv =====
// lrsr_pkg: shared types and constants for the load request slot ring
// command codes, slot status codes, field widths and the result record
// no dependencies
package lrsr_pkg;

  localparam int unsigned SLOTS_DEF = 32;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 5;
  localparam int unsigned BUSY_W  = 32;
  localparam int unsigned GSLOT_W = 5;
  localparam int unsigned PCNT_W  = 6;
  localparam int unsigned ST_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_QALL  = 2'd2,
    CMD_RENEW = 2'd3
  } cmd_t;

  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_ISSUED = 2'd1;
  localparam logic [ST_W-1:0] ST_FLIGHT = 2'd2;

  typedef struct packed {
    logic               granted;
    logic [GSLOT_W-1:0] granted_slot;
    logic               finished;
    logic               any_pending;
    logic [PCNT_W-1:0]  pending_count;
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== design/lrsr_if.sv =====
// lrsr_if: request and response channel interfaces of the slot ring
// valid/ready handshake with payload, depends on lrsr_pkg
interface lrsr_req_if;
  logic                           valid;
  logic                           ready;
  lrsr_pkg::cmd_t                 cmd;
  logic [lrsr_pkg::ID_W-1:0]      slot_id;
  logic [lrsr_pkg::BUSY_W-1:0]    busy_mask;

  modport source(output valid, cmd, slot_id, busy_mask, input ready);
  modport sink(input valid, cmd, slot_id, busy_mask, output ready);
endinterface

interface lrsr_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           granted;
  logic [lrsr_pkg::GSLOT_W-1:0]   granted_slot;
  logic                           finished;
  logic                           any_pending;
  logic [lrsr_pkg::PCNT_W-1:0]    pending_count;

  modport source(output valid, granted, granted_slot, finished, any_pending, pending_count,
                 input ready);
  modport sink(input valid, granted, granted_slot, finished, any_pending, pending_count,
               output ready);
endinterface

// ===== design/load_request_slot_ring.sv =====
// channel  dir  payload                                                  handshake
// req      in   cmd, slot_id, busy_mask                                  valid/ready
// rsp      out  granted, granted_slot, finished, any_pending, pending_count valid/ready
//
// allocate and early-answered queries: accepted, S_EXEC, S_DONE, then a loaded result
// a query that retires slots adds S_QCHK and S_WALK over up to SLOTS slots
// renew sweeps in S_RENEW: one status memory port pair visits one slot per cycle
// rst is synchronous; slot status valid bits clear at once, no clearing pass
// one transaction in work at a time; while rsp stalls one more req is taken, then held
module load_request_slot_ring #(
  parameter int unsigned SLOTS = lrsr_pkg::SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  lrsr_req_if.sink   req,
  lrsr_rsp_if.source rsp
);

  localparam int unsigned AW = $clog2(SLOTS);

  lrsr_pkg::mem_ctl_t        mem_ctl;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic [lrsr_pkg::ST_W-1:0] wr_st;
  logic [lrsr_pkg::ST_W-1:0] rd_st;
  logic                      out_free;
  logic                      out_load;
  lrsr_pkg::res_t            res;

  lrsr_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .out_free (out_free),
    .out_load (out_load),
    .res      (res),
    .mem_ctl  (mem_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_st    (wr_st),
    .rd_st    (rd_st)
  );

  lrsr_status_mem #(.SLOTS(SLOTS)) u_status_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_st   (wr_st),
    .rd_st   (rd_st)
  );

  lrsr_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .res  (res),
    .free (out_free),
    .rsp  (rsp)
  );

endmodule

// ===== design/lrsr_status_mem.sv =====
// lrsr_status_mem: slot status memory with per-slot valid bits
// one read and one write port, registered read data, depends on lrsr_pkg
module lrsr_status_mem #(
  parameter int unsigned SLOTS = lrsr_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lrsr_pkg::mem_ctl_t        ctl,
  input  logic [$clog2(SLOTS)-1:0]  rd_addr,
  input  logic [$clog2(SLOTS)-1:0]  wr_addr,
  input  logic [lrsr_pkg::ST_W-1:0] wr_st,
  output logic [lrsr_pkg::ST_W-1:0] rd_st
);

  logic [lrsr_pkg::ST_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]          vld;
  logic [lrsr_pkg::ST_W-1:0] rd_q;
  logic                      rd_vld_q;

  // done is kept as a cleared valid bit, so reset needs no sweep
  always_ff @(posedge clk) begin
    if (ctl.wr_en && wr_st != lrsr_pkg::ST_DONE) begin
      mem[wr_addr] <= wr_st;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld[wr_addr] <= (wr_st != lrsr_pkg::ST_DONE);
      end
      if (ctl.rd_en) begin
        rd_vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_st = rd_vld_q ? rd_q : lrsr_pkg::ST_DONE;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_en && ctl.wr_en |-> rd_addr != wr_addr)
    else $error("status read and write hit the same slot");

endmodule

// ===== design/lrsr_out_reg.sv =====
// lrsr_out_reg: response output register
// holds one result transaction until taken, depends on lrsr_pkg and lrsr_if
module lrsr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  lrsr_pkg::res_t     res,
  output logic               free,
  lrsr_rsp_if.source         rsp
);

  lrsr_pkg::res_t data_q;
  logic           valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= res;
    end
  end

  assign free              = !valid || rsp.ready;
  assign rsp.valid         = valid;
  assign rsp.granted       = data_q.granted;
  assign rsp.granted_slot  = data_q.granted_slot;
  assign rsp.finished      = data_q.finished;
  assign rsp.any_pending   = data_q.any_pending;
  assign rsp.pending_count = data_q.pending_count;

endmodule

// ===== design/lrsr_ctrl.sv =====
// lrsr_ctrl: command sequencer, ring pointers, retire walk and renew sweep
// drives the status memory one slot per cycle, depends on lrsr_pkg and lrsr_if
module lrsr_ctrl #(
  parameter int unsigned SLOTS = lrsr_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  lrsr_req_if.sink                  req,
  input  logic                      out_free,
  output logic                      out_load,
  output lrsr_pkg::res_t            res,
  output lrsr_pkg::mem_ctl_t        mem_ctl,
  output logic [$clog2(SLOTS)-1:0]  rd_addr,
  output logic [$clog2(SLOTS)-1:0]  wr_addr,
  output logic [lrsr_pkg::ST_W-1:0] wr_st,
  input  logic [lrsr_pkg::ST_W-1:0] rd_st
);

  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned SUMW  = CW + 1;
  localparam int unsigned IXW   = ((AW > lrsr_pkg::ID_W) ? AW : lrsr_pkg::ID_W) + 1;
  localparam int unsigned BIX_W = $clog2(lrsr_pkg::BUSY_W);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_QCHK,
    S_WALK,
    S_RENEW,
    S_DONE
  } state_t;

  state_t                        state;
  lrsr_pkg::cmd_t                cmd_q;
  logic [lrsr_pkg::ID_W-1:0]     slot_q;
  logic [lrsr_pkg::BUSY_W-1:0]   busy_q;
  logic [AW-1:0]                 head;
  logic [AW-1:0]                 tail;
  logic [CW-1:0]                 pend;
  logic [AW-1:0]                 tgt;
  logic [CW-1:0]                 cnt;
  logic [AW:0]                   sw;
  logic                          granted;
  logic [AW-1:0]                 gslot;
  logic                          fin;

  logic [SUMW-1:0] qall_sum;
  logic [AW-1:0]   qall_tgt;
  logic [IXW-1:0]  q_ix;
  logic [AW-1:0]   q_addr;
  logic            q_in_range;
  logic            q_free;
  logic            q_go;
  logic            q_fin;
  logic            alloc_ok;
  logic [AW-1:0]   rn_ix;
  logic [IXW-1:0]  rn_bx;
  logic            rn_busy;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST) ? '0 : AW'(p + 1'b1);
  endfunction

  // target of query-all is the newest pending slot
  always_comb begin
    qall_sum   = SUMW'(head) + SUMW'(pend) - SUMW'(1);
    qall_tgt   = (qall_sum >= SUMW'(SLOTS)) ? AW'(qall_sum - SUMW'(SLOTS)) : AW'(qall_sum);
    q_ix       = (cmd_q == lrsr_pkg::CMD_QALL) ? IXW'(qall_tgt) : IXW'(slot_q);
    q_addr     = q_ix[AW-1:0];
    q_in_range = (q_ix < IXW'(SLOTS));
    // free region test does not see a wrapped free region
    q_free     = (q_addr >= tail) && (q_addr < head);
    q_go       = q_in_range && !q_free && (pend != '0);
    q_fin      = (pend == '0) && (cmd_q == lrsr_pkg::CMD_QALL || (q_in_range && !q_free));
    alloc_ok   = (pend < CW'(SLOTS));
    rn_ix      = AW'(sw - 1'b1);
    rn_bx      = IXW'(rn_ix);
    rn_busy    = (rn_bx < IXW'(lrsr_pkg::BUSY_W)) && busy_q[rn_bx[BIX_W-1:0]];
  end

  always_comb begin
    mem_ctl = '0;
    rd_addr = '0;
    wr_addr = '0;
    wr_st   = lrsr_pkg::ST_DONE;
    unique case (state)
      S_EXEC: begin
        if (cmd_q == lrsr_pkg::CMD_ALLOC) begin
          if (alloc_ok) begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = tail;
            wr_st         = lrsr_pkg::ST_ISSUED;
          end
        end else if (cmd_q == lrsr_pkg::CMD_QUERY || cmd_q == lrsr_pkg::CMD_QALL) begin
          if (q_go) begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = q_addr;
          end
        end
      end
      S_WALK: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = head;
        wr_st         = lrsr_pkg::ST_DONE;
      end
      S_RENEW: begin
        // read slot sw while updating slot sw-1
        if (sw < (AW+1)'(SLOTS)) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = sw[AW-1:0];
        end
        if (sw != '0) begin
          wr_addr = rn_ix;
          if (rd_st == lrsr_pkg::ST_ISSUED) begin
            mem_ctl.wr_en = 1'b1;
            wr_st         = lrsr_pkg::ST_FLIGHT;
          end else if (rd_st == lrsr_pkg::ST_FLIGHT && !rn_busy) begin
            mem_ctl.wr_en = 1'b1;
            wr_st         = lrsr_pkg::ST_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && out_free;

  always_comb begin
    res.granted       = granted;
    res.granted_slot  = lrsr_pkg::GSLOT_W'(gslot);
    res.finished      = fin;
    res.any_pending   = (pend != '0);
    res.pending_count = lrsr_pkg::PCNT_W'(pend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      tail    <= '0;
      pend    <= '0;
      granted <= 1'b0;
      gslot   <= '0;
      fin     <= 1'b0;
      cnt     <= '0;
      sw      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q   <= req.cmd;
            slot_q  <= req.slot_id;
            busy_q  <= req.busy_mask;
            granted <= 1'b0;
            gslot   <= '0;
            fin     <= 1'b0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_q)
            lrsr_pkg::CMD_ALLOC: begin
              if (alloc_ok) begin
                granted <= 1'b1;
                gslot   <= tail;
                tail    <= ptr_inc(tail);
                pend    <= CW'(pend + 1'b1);
              end
              state <= S_DONE;
            end
            lrsr_pkg::CMD_QUERY, lrsr_pkg::CMD_QALL: begin
              if (q_go) begin
                tgt   <= q_addr;
                state <= S_QCHK;
              end else begin
                fin   <= q_fin;
                state <= S_DONE;
              end
            end
            lrsr_pkg::CMD_RENEW: begin
              sw    <= '0;
              state <= S_RENEW;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_QCHK: begin
          if (rd_st != lrsr_pkg::ST_DONE) begin
            state <= S_DONE;
          end else begin
            cnt   <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          head <= ptr_inc(head);
          if (head == tgt) begin
            pend  <= CW'(pend - CW'(cnt + 1'b1));
            fin   <= 1'b1;
            state <= S_DONE;
          end else if (CW'(cnt + 1'b1) == pend) begin
            // walk covered every pending slot without meeting the target
            fin   <= 1'b1;
            state <= S_DONE;
          end else begin
            cnt <= CW'(cnt + 1'b1);
          end
        end
        S_RENEW: begin
          if (sw == (AW+1)'(SLOTS)) begin
            state <= S_DONE;
          end else begin
            sw <= (AW+1)'(sw + 1'b1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= CW'(SLOTS))
    else $error("pending count beyond ring size");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && cmd_q == lrsr_pkg::CMD_ALLOC && alloc_ok |=>
      pend == CW'($past(pend) + 1'b1) && granted)
    else $error("allocate did not take a slot");

  a_walk_head: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |=>
      (head == AW'($past(head) + 1'b1)) || ($past(head) == LAST && head == '0))
    else $error("retire walk did not advance head");

endmodule

// ===== sim/lrsr_ring_checker.sv =====
// lrsr_ring_checker: watches the request and response channels of the slot ring,
// predicts every response from its own copy of the ring and compares field by field
// depends on lrsr_pkg and lrsr_if
module lrsr_ring_checker (
  input  logic clk,
  input  logic rst,
  lrsr_req_if  req,
  lrsr_rsp_if  rsp,
  output int   mismatches,
  output int   owed
);
  import lrsr_pkg::*;

  localparam int unsigned NS = SLOTS_DEF;

  logic [ST_W-1:0]   slot_state [NS];
  logic [ID_W-1:0]   head_slot;
  logic [ID_W-1:0]   tail_slot;
  logic [PCNT_W-1:0] pend;
  res_t              answers_due [$];
  res_t              want;
  int                bad;

  // retire from the head up to the given slot, once that slot is done
  function automatic logic retire_to(logic [ID_W-1:0] id);
    logic [ID_W-1:0]   pos;
    logic [PCNT_W-1:0] n;
    if (id >= tail_slot && id < head_slot) return 1'b0;
    if (pend == 0) return 1'b1;
    if (slot_state[id] != ST_DONE) return 1'b0;
    pos = head_slot;
    n = pend;
    for (int i = 0; i < int'(n); i++) begin
      slot_state[pos] = ST_DONE;
      head_slot = head_slot + 1'b1;
      if (pos == id) begin
        pend = pend - PCNT_W'(i + 1);
        break;
      end
      pos = pos + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic res_t step_ring(cmd_t c, logic [ID_W-1:0] id, logic [BUSY_W-1:0] busy);
    res_t r;
    r = '0;
    case (c)
      CMD_ALLOC: begin
        if (pend < NS) begin
          r.granted = 1'b1;
          r.granted_slot = tail_slot;
          slot_state[tail_slot] = ST_ISSUED;
          tail_slot = tail_slot + 1'b1;
          pend = pend + 1'b1;
        end
      end
      CMD_QUERY: r.finished = retire_to(id);
      CMD_QALL: begin
        if (pend == 0) r.finished = 1'b1;
        else r.finished = retire_to(ID_W'((int'(head_slot) + int'(pend) - 1) % NS));
      end
      default: begin
        for (int i = 0; i < NS; i++) begin
          if (slot_state[i] == ST_ISSUED) slot_state[i] = ST_FLIGHT;
          else if (slot_state[i] == ST_FLIGHT && !busy[i]) slot_state[i] = ST_DONE;
        end
      end
    endcase
    r.any_pending = (pend != 0);
    r.pending_count = pend;
    return r;
  endfunction

  always @(posedge clk) begin
    bad = 0;
    if (rst) begin
      for (int i = 0; i < NS; i++) slot_state[i] = ST_DONE;
      head_slot = '0;
      tail_slot = '0;
      pend = '0;
      answers_due.delete();
      mismatches <= 0;
      owed <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          $error("response transaction with no request outstanding");
          bad++;
        end else begin
          want = answers_due.pop_front();
          if (rsp.granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, rsp.granted);
            bad++;
          end
          if (rsp.granted_slot !== want.granted_slot) begin
            $error("granted_slot: expected %0d, actual %0d", want.granted_slot,
                   rsp.granted_slot);
            bad++;
          end
          if (rsp.finished !== want.finished) begin
            $error("finished: expected %0d, actual %0d", want.finished, rsp.finished);
            bad++;
          end
          if (rsp.any_pending !== want.any_pending) begin
            $error("any_pending: expected %0d, actual %0d", want.any_pending,
                   rsp.any_pending);
            bad++;
          end
          if (rsp.pending_count !== want.pending_count) begin
            $error("pending_count: expected %0d, actual %0d", want.pending_count,
                   rsp.pending_count);
            bad++;
          end
        end
      end
      if (req.valid && req.ready)
        answers_due.push_back(step_ring(req.cmd, req.slot_id, req.busy_mask));
      mismatches <= mismatches + bad;
      owed <= answers_due.size();
    end
  end

endmodule

// ===== sim/tb_load_request_slot_ring.sv =====
// tb_load_request_slot_ring: drives directed and random request transactions into the
// slot ring, stalls both channels at random and gives the verdict from the checker
// depends on lrsr_pkg, lrsr_if, load_request_slot_ring and lrsr_ring_checker
module tb_load_request_slot_ring;
  import lrsr_pkg::*;

  localparam int ITEMS       = 1200;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 3 * SLOTS_DEF;

  logic clk = 1'b0;
  logic rst;

  lrsr_req_if req ();
  lrsr_rsp_if rsp ();

  int              mismatches;
  int              owed;
  int              sent = 0;
  int              per_cmd [4];
  int              quiet_cycles = 0;
  bit              calm = 1'b0;
  logic [ID_W-1:0] guess_tail = '0;

  always #2 clk = ~clk;

  load_request_slot_ring dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  lrsr_ring_checker chk (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .mismatches(mismatches),
    .owed(owed)
  );

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  task automatic send_request(cmd_t c, logic [ID_W-1:0] id, logic [BUSY_W-1:0] busy);
    while (!calm && $urandom_range(99) < 9) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= c;
    req.slot_id <= id;
    req.busy_mask <= busy;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    sent++;
    per_cmd[c]++;
    calm = (sent >= 400 && sent < 650);
    if (c == CMD_ALLOC) guess_tail = guess_tail + 1'b1;
  endtask

  function automatic logic [BUSY_W-1:0] pick_busy();
    case ($urandom_range(3))
      0: return '0;
      1: return $urandom;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  initial begin
    int k;
    int m;
    for (int i = 0; i < 4; i++) per_cmd[i] = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_ALLOC;
    req.slot_id = '0;
    req.busy_mask = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty ring, then a short life of two slots
    send_request(CMD_QUERY, 5'd0, '0);
    send_request(CMD_QALL, 5'd31, '1);
    send_request(CMD_RENEW, 5'd0, '0);
    send_request(CMD_ALLOC, 5'd31, '1);
    send_request(CMD_ALLOC, 5'd0, '0);
    send_request(CMD_QALL, 5'd0, '0);
    send_request(CMD_RENEW, 5'd0, '1);
    send_request(CMD_RENEW, 5'd0, '1);
    send_request(CMD_QUERY, 5'd0, '0);
    send_request(CMD_RENEW, 5'd0, 32'h0000_0002);
    send_request(CMD_QUERY, 5'd1, '0);
    send_request(CMD_QUERY, 5'd0, '0);
    // walk that never meets the queried slot
    send_request(CMD_QUERY, 5'd5, '0);
    send_request(CMD_QALL, 5'd0, '0);
    // slot inside the unwrapped free region
    send_request(CMD_QUERY, 5'd2, '0);
    send_request(CMD_ALLOC, 5'd0, '0);
    send_request(CMD_QUERY, 5'd31, '1);
    send_request(CMD_RENEW, 5'd31, 32'h8000_0001);

    while (sent < ITEMS) begin
      m = $urandom_range(99);
      if (m < 60) begin
        k = $urandom_range(1, 6);
        repeat (k) send_request(CMD_ALLOC, ID_W'($urandom), $urandom);
        repeat ($urandom_range(1, 3)) send_request(CMD_RENEW, ID_W'($urandom), pick_busy());
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(2))
            0: send_request(CMD_QALL, ID_W'($urandom), $urandom);
            1: send_request(CMD_QUERY, ID_W'(guess_tail - $urandom_range(1, k)), $urandom);
            default: send_request(CMD_QUERY, ID_W'($urandom), $urandom);
          endcase
        end
      end else if (m < 68) begin
        // run the ring into the full condition
        repeat ($urandom_range(33, 36)) send_request(CMD_ALLOC, ID_W'($urandom), $urandom);
        send_request(CMD_RENEW, ID_W'($urandom), pick_busy());
        send_request(CMD_RENEW, ID_W'($urandom), '0);
        send_request($urandom_range(1) ? CMD_QALL : CMD_QUERY, ID_W'($urandom), $urandom);
      end else begin
        send_request(cmd_t'($urandom_range(3)), ID_W'($urandom), $urandom);
      end
    end
    req.valid <= 1'b0;
    calm = 1'b0;

    while (owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("drove %0d request transactions: %0d allocate, %0d query, %0d query-all, %0d renew",
             sent, per_cmd[CMD_ALLOC], per_cmd[CMD_QUERY], per_cmd[CMD_QALL],
             per_cmd[CMD_RENEW]);
    $display("field mismatches seen by the checker: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lrsr_pkg.sv
design/lrsr_if.sv
design/lrsr_status_mem.sv
design/lrsr_out_reg.sv
design/lrsr_ctrl.sv
design/load_request_slot_ring.sv
sim/lrsr_ring_checker.sv
sim/tb_load_request_slot_ring.sv
